### rtl/core/ris_pkg.sv
// Shared types and constants for the record insertion sorter.
package ris_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int KEY_BITS    = 32;

	typedef struct packed {
		logic [31:0] sort_key;
		logic [7:0]  record_tag;
		logic        descending;
		logic        batch_end;
	} item_t;

	typedef struct packed {
		logic [31:0] sorted_key;
		logic [7:0]  sorted_tag;
		logic        final_record;
		logic        overflowed;
	} result_t;

	// One stored record as held by a cell.
	typedef struct packed {
		logic                valid;
		logic [KEY_BITS-1:0] key;
		logic [7:0]          tag;
	} rec_t;

	// Control broadcast to every cell of the row.
	typedef struct packed {
		logic                insert;
		logic                shift;
		logic                desc;
		logic [KEY_BITS-1:0] key;
		logic [7:0]          tag;
	} cell_ctrl_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

endpackage

### rtl/core/ris_cell.sv
// One cell of the sorting row: holds a record, compares, and shifts.
module ris_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  ris_pkg::cell_ctrl_t ctrl,
	input  ris_pkg::rec_t     prev_rec,
	input  logic              prev_keep,
	input  ris_pkg::rec_t     next_rec,
	output ris_pkg::rec_t     rec,
	output logic              keep
);

	logic                       valid_q;
	logic [ris_pkg::KEY_BITS-1:0] key_q;
	logic [7:0]                 tag_q;

	// A stored record stays in front of the arriving one unless it is strictly
	// on the far side; equal keys stay in front, which keeps the sort stable.
	always_comb begin
		if (ctrl.desc) begin
			keep = valid_q && !(key_q < ctrl.key);
		end else begin
			keep = valid_q && !(key_q > ctrl.key);
		end
	end

	assign rec = '{valid: valid_q, key: key_q, tag: tag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_rec.valid;
		end else if (ctrl.insert && !keep) begin
			valid_q <= prev_keep ? 1'b1 : prev_rec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q <= next_rec.key;
			tag_q <= next_rec.tag;
		end else if (ctrl.insert && !keep) begin
			if (prev_keep) begin
				key_q <= ctrl.key;
				tag_q <= ctrl.tag;
			end else begin
				key_q <= prev_rec.key;
				tag_q <= prev_rec.tag;
			end
		end
	end

endmodule

### rtl/core/ris_row.sv
// Row of sorting cells, linked to their neighbors on both sides.
module ris_row (
	input  logic              clk,
	input  logic              arst_n,
	input  ris_pkg::cell_ctrl_t ctrl,
	output ris_pkg::rec_t     head,
	output ris_pkg::rec_t     second,
	output logic              full
);

	ris_pkg::rec_t recs  [ris_pkg::MAX_RECORDS];
	logic          keeps [ris_pkg::MAX_RECORDS];

	for (genvar i = 0; i < ris_pkg::MAX_RECORDS; i++) begin : g_cell
		ris_pkg::rec_t prev_rec;
		ris_pkg::rec_t next_rec;
		logic          prev_keep;

		if (i == 0) begin : g_first
			assign prev_rec  = '0;
			assign prev_keep = 1'b1;
		end else begin : g_mid
			assign prev_rec  = recs[i-1];
			assign prev_keep = keeps[i-1];
		end

		if (i == ris_pkg::MAX_RECORDS - 1) begin : g_last
			assign next_rec = '0;
		end else begin : g_inner
			assign next_rec = recs[i+1];
		end

		ris_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.prev_rec (prev_rec),
			.prev_keep(prev_keep),
			.next_rec (next_rec),
			.rec      (recs[i]),
			.keep     (keeps[i])
		);
	end

	assign head   = recs[0];
	assign second = recs[1];
	assign full   = recs[ris_pkg::MAX_RECORDS-1].valid;

endmodule

### rtl/core/record_insertion_sorter.sv
// Top level of the record insertion sorter.
//
// Records enter on the item channel (valid/ready), one word per cycle. Each
// accepted record is placed into a row of 64 compare-and-shift cells in the
// cycle it is accepted, so loading runs at one record per cycle. The sort
// direction is taken from the first record of a batch. Records that arrive
// while all cells are occupied are dropped and the batch is marked overflowed.
// A record with batch_end set ends the batch: from the next cycle on, the row
// drains through its first cell onto the result channel, one word per cycle
// while result_ready is high, smallest first (largest first when descending).
// The first result word is valid in the cycle after the batch end is accepted,
// and each stored record leaves as one result word. item_ready is low during
// the drain. A stalled receiver simply freezes the row; the word on the result
// port is a cell register and holds until taken. The last word carries
// final_record, after which loading resumes in the next cycle. Reset empties
// the row, clears the overflow mark and sets the direction to ascending.
module record_insertion_sorter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  ris_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output ris_pkg::result_t result
);

	ris_pkg::state_t     state_q;
	ris_pkg::state_t     state_next;
	logic                dir_q;
	logic                drop_q;
	logic                item_acc;
	logic                result_acc;
	logic                dir_now;
	ris_pkg::cell_ctrl_t ctrl;
	ris_pkg::rec_t       head;
	ris_pkg::rec_t       second;
	logic                full;

	assign item_acc   = item_valid && item_ready;
	assign result_acc = result_valid && result_ready;

	// An empty row means this record opens a new batch.
	assign dir_now = head.valid ? dir_q : item.descending;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ris_pkg::ST_LOAD: begin
				if (item_acc && item.batch_end) begin
					state_next = ris_pkg::ST_DRAIN;
				end
			end
			ris_pkg::ST_DRAIN: begin
				if (result_acc && !second.valid) begin
					state_next = ris_pkg::ST_LOAD;
				end
			end
			default: state_next = ris_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		item_ready   = 1'b0;
		result_valid = 1'b0;
		case (state_q)
			ris_pkg::ST_LOAD:  item_ready = 1'b1;
			ris_pkg::ST_DRAIN: result_valid = head.valid;
			default: begin
				item_ready   = 1'b0;
				result_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ris_pkg::ST_LOAD;
			dir_q   <= 1'b0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			if (item_acc) begin
				dir_q <= dir_now;
				if (full) begin
					drop_q <= 1'b1;
				end
			end else if (result_acc && !second.valid) begin
				drop_q <= 1'b0;
			end
		end
	end

	assign ctrl.insert = item_acc && !full;
	assign ctrl.shift  = result_acc;
	assign ctrl.desc   = dir_now;
	assign ctrl.key    = ris_pkg::KEY_BITS'(item.sort_key);
	assign ctrl.tag    = item.record_tag;

	ris_row u_row (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.head  (head),
		.second(second),
		.full  (full)
	);

	assign result.sorted_key   = 32'(head.key);
	assign result.sorted_tag   = head.tag;
	assign result.final_record = !second.valid;
	assign result.overflowed   = drop_q;

	// During the drain, the first two cells are in sorted order.
	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ris_pkg::ST_DRAIN) && second.valid |->
		(dir_q ? (head.key >= second.key) : (head.key <= second.key)))
		else $error("sorted row out of order at its head");

	// Taking the final word leaves an empty row ready to load.
	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_acc && result.final_record |=> item_ready && !head.valid)
		else $error("row not empty after final word");

	// The overflow mark holds steady across the drain.
	a_drop_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ris_pkg::ST_DRAIN) && $past(state_q == ris_pkg::ST_DRAIN) |->
		$stable(drop_q))
		else $error("overflow mark changed during drain");

	// A drain never starts on an empty row.
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && item.batch_end |=> result_valid)
		else $error("batch end left nothing to send");

endmodule
